>>> src/sfd_pkg.sv
// ============================================================================
// sfd_pkg: shared types and constants for the frame deframer
// Address codes, register reset value, queue item layout and CRC-8 step.
// ============================================================================
`default_nettype none

package sfd_pkg;

    // Default size of the frame store in bytes
    localparam int FRAME_BYTES_DEF = 64;

    // Start address codes that open a frame
    localparam logic [7:0] ADDR_FC    = 8'hC8;
    localparam logic [7:0] ADDR_EA    = 8'hEA;
    localparam logic [7:0] ADDR_BCAST = 8'h00;

    // Reset value of the maximum frame length register
    localparam logic [5:0] MAX_LEN_RESET = 6'd62;

    // CRC-8 polynomial and top-bit mask
    localparam logic [7:0] CRC_POLY = 8'hD5;
    localparam logic [7:0] CRC_MSB  = 8'h80;

    // One result item waiting for delivery
    typedef struct packed {
        logic [7:0] data;
        logic [5:0] index;
        logic [7:0] address;
        logic       last;
    } out_item_t;

    // Advance the CRC over one byte, MSB first
    function automatic logic [7:0] crc8_update(input logic [7:0] acc, input logic [7:0] b);
        logic [7:0] c;
        c = acc ^ b;
        for (int i = 0; i < 8; i++) begin
            if ((c & CRC_MSB) != 8'h00) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

>>> src/sfd_out_queue.sv
// ============================================================================
// sfd_out_queue: two-entry output queue
// Head register drives the output port; a spare entry absorbs the read that
// is already in flight when the consumer stalls.
// ============================================================================
`default_nettype none

module sfd_out_queue
    import sfd_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  wire out_item_t push_item,
    input  wire logic      out_stall,
    output logic           out_valid,
    output out_item_t      head_item,
    output logic [1:0]     occupancy
);

    logic      head_valid_reg, head_valid_next;
    logic      spare_valid_reg, spare_valid_next;
    out_item_t head_reg, head_next;
    out_item_t spare_reg, spare_next;
    logic      take;

    // Head frees when empty or when its item is taken
    assign take = !head_valid_reg || !out_stall;

    // Refill head from spare first, then from the incoming read
    always_comb
    begin
        head_valid_next  = head_valid_reg;
        head_next        = head_reg;
        spare_valid_next = spare_valid_reg;
        spare_next       = spare_reg;
        if (take) begin
            if (spare_valid_reg) begin
                head_valid_next  = 1'b1;
                head_next        = spare_reg;
                spare_valid_next = push;
                spare_next       = push_item;
            end else begin
                head_valid_next = push;
                head_next       = push_item;
            end
        end else if (push) begin
            spare_valid_next = 1'b1;
            spare_next       = push_item;
        end
    end

    // Clear valid bits under reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            head_valid_reg  <= 1'b0;
            spare_valid_reg <= 1'b0;
        end else begin
            head_valid_reg  <= head_valid_next;
            spare_valid_reg <= spare_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        head_reg  <= head_next;
        spare_reg <= spare_next;
    end

    assign out_valid = head_valid_reg;
    assign head_item = head_reg;
    assign occupancy = {1'b0, head_valid_reg} + {1'b0, spare_valid_reg};

endmodule

`default_nettype wire

>>> src/sync_frame_deframer_crc8.sv
// ============================================================================
// sync_frame_deframer_crc8: framed byte receiver with CRC-8 check
// Finds a start address, checks the length, stores the frame in a byte
// memory and replays type and payload of frames whose CRC-8 matches.
// ============================================================================
//
//  Channel   Direction  Handshake            Payload
//  -------   ---------  -------------------  ---------------------------------
//  in        input      in_valid / in_stall  rx_byte
//  out       output     out_valid/out_stall  frame_byte, byte_index,
//                                            start_address, last_flag
//  cfg       input      cfg_we               cfg_wdata (max frame length)
//
//  A good frame of length L (type, payload and check byte) replays L-1
//  items one per cycle unless the output stalls, from the store's single
//  read port; in_stall stays high, and no received byte is taken, until
//  the last read issues. Output stalls throttle the reads through a two-entry
//  output queue. Reset clears the parser and the queue; the store itself is
//  not cleared, since only bytes written by the current frame are ever read.
//
`default_nettype none

module sync_frame_deframer_crc8
    import sfd_pkg::*;
#(
    parameter int FRAME_BYTES = FRAME_BYTES_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic [5:0] cfg_wdata,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] rx_byte,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      frame_byte,
    output logic [5:0]      byte_index,
    output logic [7:0]      start_address,
    output logic            last_flag
);

    localparam int PW = $clog2(FRAME_BYTES);
    localparam logic [8:0]  LEN_CAP  = 9'(FRAME_BYTES - 2);
    localparam logic [PW:0] ONE_W    = 1;
    localparam logic [PW-1:0] POS_ONE   = 1;
    localparam logic [PW-1:0] POS_TWO   = 2;
    localparam logic [PW-1:0] POS_THREE = 3;

    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_HEADER = 2'd1;
    localparam logic [1:0] PH_BODY   = 2'd2;

    // Parser and drain state
    logic [5:0]    max_len_reg;
    logic [1:0]    phase_reg, phase_next;
    logic [PW-1:0] pos_reg, pos_next;
    logic [7:0]    len_byte_reg, len_byte_next;
    logic [PW-1:0] len_reg, len_next;
    logic [7:0]    crc_reg, crc_next;
    logic [7:0]    addr_reg, addr_next;
    logic          drain_active_reg, drain_active_next;
    logic [PW-1:0] drain_k_reg, drain_k_next;
    logic [PW-1:0] drain_last_k_reg, drain_last_k_next;
    logic          rd_valid_reg;
    logic [7:0]    rd_data_reg;
    logic [PW-1:0] rd_k_reg;
    logic          rd_last_reg;

    // Frame store
    logic [7:0]    store [FRAME_BYTES];

    logic          in_acc;
    logic          wr_en;
    logic [PW-1:0] wr_addr;
    logic [PW-1:0] rd_addr;
    logic          issue;
    logic          pop;
    logic          len_ok;
    logic [1:0]    occupancy;
    out_item_t     push_item;
    out_item_t     head_item;

    assign in_stall = drain_active_reg;
    assign in_acc   = in_valid && !drain_active_reg;

    // Judge the length byte against the register and the store size
    assign len_ok = (len_byte_reg >= 8'd2) &&
                    (len_byte_reg <= {2'b00, max_len_reg}) &&
                    ({1'b0, len_byte_reg} <= LEN_CAP);

    // Issue a store read while the queue and the read in flight leave room
    assign pop   = out_valid && !out_stall;
    assign issue = drain_active_reg &&
                   (({1'b0, occupancy} + {2'b00, rd_valid_reg}) < (3'd2 + {2'b00, pop}));
    assign rd_addr = drain_k_reg + POS_TWO;

    // Parse one received byte and start the replay of a good frame
    always_comb
    begin
        phase_next        = phase_reg;
        pos_next          = pos_reg;
        len_byte_next     = len_byte_reg;
        len_next          = len_reg;
        crc_next          = crc_reg;
        addr_next         = addr_reg;
        drain_active_next = drain_active_reg;
        drain_k_next      = drain_k_reg;
        drain_last_k_next = drain_last_k_reg;
        wr_en             = 1'b0;
        wr_addr           = pos_reg;

        unique case (phase_reg)
            PH_IDLE:
            begin
                if (in_acc && (rx_byte == ADDR_EA || rx_byte == ADDR_FC ||
                               rx_byte == ADDR_BCAST)) begin
                    wr_en      = 1'b1;
                    wr_addr    = '0;
                    addr_next  = rx_byte;
                    pos_next   = POS_ONE;
                    crc_next   = 8'h00;
                    phase_next = PH_HEADER;
                end
            end
            PH_HEADER:
            begin
                if (in_acc) begin
                    wr_en = 1'b1;
                    if (pos_reg >= POS_TWO) begin
                        crc_next = crc8_update(8'h00, rx_byte);
                        if (len_ok) begin
                            len_next   = len_byte_reg[PW-1:0];
                            pos_next   = POS_THREE;
                            phase_next = PH_BODY;
                        end else begin
                            pos_next   = '0;
                            phase_next = PH_IDLE;
                        end
                    end else begin
                        len_byte_next = rx_byte;
                        pos_next      = pos_reg + POS_ONE;
                    end
                end
            end
            PH_BODY:
            begin
                if (in_acc) begin
                    wr_en = 1'b1;
                    if ({1'b0, pos_reg} >= ({1'b0, len_reg} + ONE_W)) begin
                        // Check byte: replay type and payload on a match
                        if (crc_reg == rx_byte) begin
                            drain_active_next = 1'b1;
                            drain_k_next      = '0;
                            drain_last_k_next = len_reg - POS_TWO;
                        end
                        pos_next   = '0;
                        phase_next = PH_IDLE;
                    end else begin
                        crc_next = crc8_update(crc_reg, rx_byte);
                        pos_next = pos_reg + POS_ONE;
                    end
                end
            end
            default:
            begin
                if (in_acc) begin
                    pos_next   = '0;
                    phase_next = PH_IDLE;
                end
            end
        endcase

        // Advance the replay counter
        if (issue) begin
            drain_k_next = drain_k_reg + POS_ONE;
            if (drain_k_reg == drain_last_k_reg) begin
                drain_active_next = 1'b0;
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            max_len_reg      <= MAX_LEN_RESET;
            phase_reg        <= PH_IDLE;
            pos_reg          <= '0;
            len_byte_reg     <= 8'h00;
            len_reg          <= '0;
            crc_reg          <= 8'h00;
            addr_reg         <= 8'h00;
            drain_active_reg <= 1'b0;
            drain_k_reg      <= '0;
            drain_last_k_reg <= '0;
            rd_valid_reg     <= 1'b0;
        end else begin
            if (cfg_we) begin
                max_len_reg <= cfg_wdata;
            end
            phase_reg        <= phase_next;
            pos_reg          <= pos_next;
            len_byte_reg     <= len_byte_next;
            len_reg          <= len_next;
            crc_reg          <= crc_next;
            addr_reg         <= addr_next;
            drain_active_reg <= drain_active_next;
            drain_k_reg      <= drain_k_next;
            drain_last_k_reg <= drain_last_k_next;
            rd_valid_reg     <= issue;
        end
    end

    // Store write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en) begin
            store[wr_addr] <= rx_byte;
        end
        if (issue) begin
            rd_data_reg <= store[rd_addr];
            rd_k_reg    <= drain_k_reg;
            rd_last_reg <= (drain_k_reg == drain_last_k_reg);
        end
    end

    // Queue the read data for delivery
    always_comb
    begin
        push_item.data    = rd_data_reg;
        push_item.index   = 6'(rd_k_reg);
        push_item.address = addr_reg;
        push_item.last    = rd_last_reg;
    end

    sfd_out_queue u_out_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (rd_valid_reg),
        .push_item (push_item),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .head_item (head_item),
        .occupancy (occupancy)
    );

    assign frame_byte    = head_item.data;
    assign byte_index    = head_item.index;
    assign start_address = head_item.address;
    assign last_flag     = head_item.last;

endmodule

`default_nettype wire

>>> src/sfd_checker.sv
// ============================================================================
// sfd_checker: port-level checks for the frame deframer
// Watches the top-level ports for ordering of replayed items and stalls.
// ============================================================================
`default_nettype none

module sfd_checker
    import sfd_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_stall,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic [7:0] frame_byte,
    input wire logic [5:0] byte_index,
    input wire logic [7:0] start_address,
    input wire logic       last_flag
);

    // Hold a stalled output item
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(frame_byte) &&
            $stable(byte_index) && $stable(start_address) && $stable(last_flag))
    else $error("stalled output item changed");

    // Start a replay only after a received byte was taken
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_stall) |-> $past(in_valid && !in_stall))
    else $error("input stall rose without an accepted item");

    // Advance the index by one within a run
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !last_flag) ##1 (out_valid && !out_stall) |->
            byte_index == 6'($past(byte_index) + 6'd1) && $stable(start_address))
    else $error("run index did not advance");

    // Open a new run at index zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && last_flag) ##1 (out_valid && !out_stall) |->
            byte_index == 6'd0)
    else $error("run did not restart at index zero");

    // Carry only a valid start address
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (start_address == ADDR_EA || start_address == ADDR_FC ||
                       start_address == ADDR_BCAST))
    else $error("output carries an unknown start address");

endmodule

bind sync_frame_deframer_crc8 sfd_checker u_sfd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .frame_byte    (frame_byte),
    .byte_index    (byte_index),
    .start_address (start_address),
    .last_flag     (last_flag)
);

`default_nettype wire
